[sv/mcbcs_pkg.sv]
// Shared types and constants for the multi-channel blink code sequencer.
// No dependencies; compiled first.
`default_nettype none

package mcbcs_pkg;

  localparam int CHANNELS = 4;
  // only the low channels appear in the result masks
  localparam int MASK_W   = 4;
  localparam int MASK_CH  = (CHANNELS < MASK_W) ? CHANNELS : MASK_W;

  localparam int CNT_W    = 16;
  localparam int CHAN_W   = 2;
  localparam int REG_IDX_W = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_LIGHT    = 2'd1,
    PH_INTERVAL = 2'd2,
    PH_WAIT     = 2'd3
  } phase_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_LIGHT_TICKS    = 2'd0,
    REG_INTERVAL_TICKS = 2'd1,
    REG_WAIT_TICKS     = 2'd2
  } reg_idx_t;

  typedef enum logic {
    REQ_TICK  = 1'b0,
    REQ_BLINK = 1'b1
  } req_type_t;

  localparam logic [CNT_W-1:0] LIGHT_TICKS_RST    = 16'd10;
  localparam logic [CNT_W-1:0] INTERVAL_TICKS_RST = 16'd10;
  localparam logic [CNT_W-1:0] WAIT_TICKS_RST     = 16'd50;

endpackage

`default_nettype wire

[sv/mcbcs_if.sv]
// Valid/ready channel interfaces for request beats and result beats.
// Depends on mcbcs_pkg.
`default_nettype none

interface mcbcs_req_if
  import mcbcs_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [CHAN_W-1:0] channel;
  logic [CNT_W-1:0]  blink_count;

  modport source (output valid, req_type, channel, blink_count, input ready);
  modport sink   (input valid, req_type, channel, blink_count, output ready);
endinterface

interface mcbcs_res_if
  import mcbcs_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] lamp_mask;
  logic [MASK_W-1:0] busy_mask;

  modport source (output valid, lamp_mask, busy_mask, input ready);
  modport sink   (input valid, lamp_mask, busy_mask, output ready);
endinterface

`default_nettype wire

[sv/multi_channel_blink_code_sequencer_core.sv]
// Blink code sequencer top level: per-channel phase machines and result register.
// Depends on mcbcs_pkg and the channel interfaces in mcbcs_if.sv.
//
//   port   dir  beat contents
//   req    in   req_type, channel, blink_count
//   res    out  lamp_mask, busy_mask
//   cfg    in   cfg_we, cfg_index, cfg_data (write only)
//
// Every accepted beat updates all channel machines in the same cycle and
// loads the result register; its masks appear on res the next cycle.
// One beat per cycle; the single result register sets that figure.
// req.ready drops only while a result is held and res.ready is low.
// rst (synchronous) returns every channel to idle with counts cleared and
// restores the default timing registers.
`default_nettype none

module multi_channel_blink_code_sequencer_core
  import mcbcs_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [REG_IDX_W-1:0] cfg_index,
  input  wire logic [CNT_W-1:0]     cfg_data,
  mcbcs_req_if.sink                 req,
  mcbcs_res_if.source               res
);

  logic [CNT_W-1:0] light_ticks;
  logic [CNT_W-1:0] interval_ticks;
  logic [CNT_W-1:0] wait_ticks;

  phase_t           phase         [CHANNELS];
  logic [CNT_W-1:0] tick_count    [CHANNELS];
  logic [CNT_W-1:0] pending_count [CHANNELS];
  logic [CNT_W-1:0] target_count  [CHANNELS];
  logic [CNT_W-1:0] blinks_done   [CHANNELS];

  phase_t           phase_next         [CHANNELS];
  logic [CNT_W-1:0] tick_count_next    [CHANNELS];
  logic [CNT_W-1:0] pending_count_next [CHANNELS];
  logic [CNT_W-1:0] target_count_next  [CHANNELS];
  logic [CNT_W-1:0] blinks_done_next   [CHANNELS];

  logic              res_valid;
  logic [MASK_W-1:0] lamp_mask;
  logic [MASK_W-1:0] busy_mask;
  logic [MASK_W-1:0] lamp_mask_next;
  logic [MASK_W-1:0] busy_mask_next;
  logic              accept;

  assign req.ready     = !res_valid || res.ready;
  assign accept        = req.valid && req.ready;
  assign res.valid     = res_valid;
  assign res.lamp_mask = lamp_mask;
  assign res.busy_mask = busy_mask;

  // Timing registers
  always_ff @(posedge clk) begin
    if (rst) begin
      light_ticks    <= LIGHT_TICKS_RST;
      interval_ticks <= INTERVAL_TICKS_RST;
      wait_ticks     <= WAIT_TICKS_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_LIGHT_TICKS:    light_ticks    <= cfg_data;
        REG_INTERVAL_TICKS: interval_ticks <= cfg_data;
        REG_WAIT_TICKS:     wait_ticks     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Channel machines: all channels step side by side
  always_comb begin
    logic [CNT_W-1:0] tick_inc;
    for (int c = 0; c < CHANNELS; c++) begin
      phase_next[c]         = phase[c];
      tick_count_next[c]    = tick_count[c];
      pending_count_next[c] = pending_count[c];
      target_count_next[c]  = target_count[c];
      blinks_done_next[c]   = blinks_done[c];
      tick_inc = (tick_count[c] == CNT_MAX) ? tick_count[c] : tick_count[c] + 1'b1;

      if (req_type_t'(req.req_type) == REQ_BLINK) begin
        // out-of-range channels match no entry and are dropped
        if (c == int'(req.channel)) begin
          pending_count_next[c] = req.blink_count;
        end
      end else begin
        tick_count_next[c] = tick_inc;
        case (phase[c])
          PH_IDLE: begin
            if (pending_count[c] != '0) begin
              target_count_next[c]  = pending_count[c];
              pending_count_next[c] = '0;
              tick_count_next[c]    = '0;
              blinks_done_next[c]   = CNT_W'(1);
              phase_next[c]         = PH_LIGHT;
            end
          end
          PH_LIGHT: begin
            if (tick_inc >= light_ticks) begin
              tick_count_next[c] = '0;
              phase_next[c]      = PH_INTERVAL;
            end
          end
          PH_INTERVAL: begin
            if (tick_inc >= interval_ticks) begin
              tick_count_next[c] = '0;
              if (blinks_done[c] >= target_count[c]) begin
                target_count_next[c] = '0;
                phase_next[c]        = PH_WAIT;
              end else begin
                if (blinks_done[c] != CNT_MAX) begin
                  blinks_done_next[c] = blinks_done[c] + 1'b1;
                end
                phase_next[c] = PH_LIGHT;
              end
            end
          end
          PH_WAIT: begin
            if (tick_inc >= wait_ticks) begin
              tick_count_next[c] = '0;
              phase_next[c]      = PH_IDLE;
            end
          end
          default: ;
        endcase
      end
    end

    lamp_mask_next = '0;
    busy_mask_next = '0;
    for (int c = 0; c < MASK_CH; c++) begin
      lamp_mask_next[c] = (phase_next[c] == PH_LIGHT);
      busy_mask_next[c] = (phase_next[c] != PH_IDLE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        phase[c]         <= PH_IDLE;
        tick_count[c]    <= '0;
        pending_count[c] <= '0;
        target_count[c]  <= '0;
        blinks_done[c]   <= '0;
      end
    end else if (accept) begin
      for (int c = 0; c < CHANNELS; c++) begin
        phase[c]         <= phase_next[c];
        tick_count[c]    <= tick_count_next[c];
        pending_count[c] <= pending_count_next[c];
        target_count[c]  <= target_count_next[c];
        blinks_done[c]   <= blinks_done_next[c];
      end
    end
  end

  // Result register: load on accept, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lamp_mask <= lamp_mask_next;
      busy_mask <= busy_mask_next;
    end
  end

endmodule

`default_nettype wire
